@@ design/window_equal_pair_counter_top_assert.svh @@
// Assertion macros for the window equal pair counter.
// Depends on nothing; included by the top level.
`ifndef WINDOW_EQUAL_PAIR_COUNTER_TOP_ASSERT_SVH
`define WINDOW_EQUAL_PAIR_COUNTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WEPC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wepc implication check failed");
`define WEPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wepc next-cycle check failed");
`else
`define WEPC_ASSERT_IMPL(lbl, ante, cons)
`define WEPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/wepc_pkg.sv @@
// Shared constants and types for the window equal pair counter.
// Depends on nothing.
package wepc_pkg;
   localparam int ELEMENTS  = 65536;
   localparam int IDX_W     = $clog2(ELEMENTS);
   localparam int POS_W     = IDX_W + 1;
   localparam int COLORS    = 65536;
   localparam int COLOR_W   = 16;
   localparam int CNT_W     = 17;
   localparam int PAIR_W    = 32;
   localparam int WIDTH_W   = 17;
   localparam int CLR_DEPTH = (ELEMENTS > COLORS) ? ELEMENTS : COLORS;
   localparam int CLR_W     = $clog2(CLR_DEPTH);

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_QUERY    = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ORDER = 1'b1;

   typedef struct packed {
      logic                 err;
      logic [PAIR_W-1:0]    pairs;
      logic [WIDTH_W-1:0]   width;
   } red_req_type;

   typedef struct packed {
      logic [30:0] numerator;
      logic [30:0] denominator;
      logic        status;
   } red_rsp_type;
endpackage

@@ design/window_equal_pair_counter_top.sv @@
// Window equal pair counter: top level. Depends on wepc_pkg, wepc_core, wepc_reduce.
// The core takes one word at a time. A load outside the window only writes the element
// store; a load inside it also updates the histogram. A query moves the window edges one element at a time
// (element read, then the dependent histogram read), then runs the binary gcd steps and
// 64 division steps. Reset: synchronous; req_ready then stays low while both memories
// are swept to zero, one entry per cycle.
`include "window_equal_pair_counter_top_assert.svh"
module window_equal_pair_counter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_elem_index,
   input  logic [15:0] req_elem_color,
   input  logic [15:0] req_query_left,
   input  logic [15:0] req_query_right,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_numerator,
   output logic [30:0] rsp_denominator,
   output logic        rsp_status
);
   wepc_pkg::red_req_type red_req;
   wepc_pkg::red_rsp_type red_rsp, out_ff, out_in;
   logic red_req_valid, red_req_ready, red_rsp_valid, red_rsp_ready;
   logic core_ready;
   logic valid_ff, valid_in;

   // The core walks the window and keeps the pair total.
   wepc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && core_ready),
      .cmd       (req_command),
      .idx       (req_elem_index),
      .col       (req_elem_color),
      .ql        (req_query_left),
      .qr        (req_query_right),
      .ready     (core_ready),
      .red_req   (red_req),
      .red_valid (red_req_valid),
      .red_ready (red_req_ready)
   );

   // The reducer turns the pair total into a reduced fraction.
   wepc_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .req       (red_req),
      .req_valid (red_req_valid),
      .req_ready (red_req_ready),
      .rsp       (red_rsp),
      .rsp_valid (red_rsp_valid),
      .rsp_ready (red_rsp_ready)
   );

   // Output word register: take a new word when empty or being drained.
   always_comb begin
      red_rsp_ready = !valid_ff || rsp_ready;
      valid_in = valid_ff;
      out_in = out_ff;
      if (red_rsp_ready) begin
         valid_in = red_rsp_valid;
         if (red_rsp_valid) begin
            out_in = red_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign req_ready       = core_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_numerator   = out_ff.numerator;
   assign rsp_denominator = out_ff.denominator;
   assign rsp_status      = out_ff.status;

   `WEPC_ASSERT_IMPL(a_den_nonzero, rsp_valid, rsp_denominator != 31'd0)
   `WEPC_ASSERT_IMPL(a_err_zero_one, rsp_valid && rsp_status, rsp_numerator == '0 && rsp_denominator == 31'd1)
   `WEPC_ASSERT_IMPL(a_num_le_den, rsp_valid, rsp_numerator <= rsp_denominator)
   `WEPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_numerator))
endmodule

@@ design/wepc_core.sv @@
// Element store, color histogram and window walker.
// Depends on wepc_pkg.
module wepc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        cmd,
   input  logic [15:0]                 idx,
   input  logic [15:0]                 col,
   input  logic [15:0]                 ql,
   input  logic [15:0]                 qr,
   output logic                        ready,
   output wepc_pkg::red_req_type       red_req,
   output logic                        red_valid,
   input  logic                        red_ready
);
   localparam logic [31:0] LAST = 32'(wepc_pkg::ELEMENTS - 1);
   localparam int IW = wepc_pkg::IDX_W;
   localparam int PW = wepc_pkg::POS_W;
   localparam int CW = wepc_pkg::CLR_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_PICK, S_ELEM, S_HIST, S_LNEW, S_HAND
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [PW-1:0] left_ff, left_in, right_ff, right_in, ql_ff, ql_in, qr_ff, qr_in;
   logic [wepc_pkg::PAIR_W-1:0] pair_ff, pair_in;
   logic op_add_ff, op_add_in, ld_ff, ld_in, err_ff, err_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [15:0] col_ff, col_in, color_ff, color_in;
   logic [wepc_pkg::WIDTH_W-1:0] width_ff, width_in;

   logic [15:0] elem_mem [wepc_pkg::ELEMENTS];
   logic [wepc_pkg::CNT_W-1:0] hist_mem [wepc_pkg::COLORS];
   logic [15:0] elem_q;
   logic [wepc_pkg::CNT_W-1:0] hist_q;

   logic [31:0] ql_ext, qr_ext, ql_sat, qr_sat, idx_ext;
   logic [PW-1:0] idx_pos, step_pos;
   logic idx_ok, in_win, grow_l, grow_r, shr_l, shr_r;
   logic [IW-1:0] elem_raddr, elem_waddr;
   logic [15:0] hist_raddr, elem_wdata;
   logic elem_we, hist_we;
   logic [wepc_pkg::CNT_W-1:0] hist_wdata;
   logic [15:0] hist_waddr;

   always_comb begin
      ql_ext  = {16'b0, ql};
      qr_ext  = {16'b0, qr};
      idx_ext = {16'b0, idx};
      ql_sat  = (ql_ext > LAST) ? LAST : ql_ext;
      qr_sat  = (qr_ext > LAST) ? LAST : qr_ext;
      idx_ok  = idx_ext <= LAST;
      idx_pos = idx_ext[PW-1:0];
      in_win  = (idx_pos >= left_ff) && (idx_pos <= right_ff);
      grow_l  = left_ff > ql_ff;
      grow_r  = right_ff < qr_ff;
      shr_l   = left_ff < ql_ff;
      shr_r   = right_ff > qr_ff;
      if (grow_l) begin
         step_pos = left_ff - PW'(1);
      end else if (grow_r) begin
         step_pos = right_ff + PW'(1);
      end else if (shr_l) begin
         step_pos = left_ff;
      end else begin
         step_pos = right_ff;
      end
      elem_raddr = (state_ff == S_IDLE) ? idx_pos[IW-1:0] : step_pos[IW-1:0];
      hist_raddr = (state_ff == S_ELEM) ? elem_q : color_ff;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      ql_in     = ql_ff;
      qr_in     = qr_ff;
      pair_in   = pair_ff;
      op_add_in = op_add_ff;
      ld_in     = ld_ff;
      err_in    = err_ff;
      idx_in    = idx_ff;
      col_in    = col_ff;
      color_in  = color_ff;
      width_in  = width_ff;
      elem_we    = 1'b0;
      elem_waddr = idx_ff;
      elem_wdata = col_ff;
      hist_we    = 1'b0;
      hist_waddr = color_ff;
      hist_wdata = hist_q + wepc_pkg::CNT_W'(1);
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CW'(1);
            elem_we    = ({1'b0, clr_ff} < (CW+1)'(wepc_pkg::ELEMENTS));
            elem_waddr = clr_ff[IW-1:0];
            elem_wdata = '0;
            hist_we    = ({1'b0, clr_ff} < (CW+1)'(wepc_pkg::COLORS));
            hist_waddr = clr_ff[15:0];
            hist_wdata = '0;
            if (clr_ff == CW'(wepc_pkg::CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (cmd == wepc_pkg::CMD_LOAD) begin
                  if (idx_ok && in_win) begin
                     ld_in     = 1'b1;
                     op_add_in = 1'b0;
                     idx_in    = idx_pos[IW-1:0];
                     col_in    = col;
                     state_in  = S_ELEM;
                  end else if (idx_ok) begin
                     elem_we    = 1'b1;
                     elem_waddr = idx_pos[IW-1:0];
                     elem_wdata = col;
                  end
               end else begin
                  ld_in = 1'b0;
                  if (ql > qr) begin
                     err_in   = 1'b1;
                     state_in = S_HAND;
                  end else begin
                     err_in   = 1'b0;
                     ql_in    = ql_sat[PW-1:0];
                     qr_in    = qr_sat[PW-1:0];
                     width_in = 17'(qr_sat - ql_sat + 32'd1);
                     state_in = S_PICK;
                  end
               end
            end
         end
         S_PICK: begin
            // grow first, then shrink, so counts never underflow
            if (grow_l) begin
               left_in = left_ff - PW'(1);
               op_add_in = 1'b1;
               state_in = S_ELEM;
            end else if (grow_r) begin
               right_in = right_ff + PW'(1);
               op_add_in = 1'b1;
               state_in = S_ELEM;
            end else if (shr_l) begin
               left_in = left_ff + PW'(1);
               op_add_in = 1'b0;
               state_in = S_ELEM;
            end else if (shr_r) begin
               right_in = right_ff - PW'(1);
               op_add_in = 1'b0;
               state_in = S_ELEM;
            end else begin
               state_in = S_HAND;
            end
         end
         S_ELEM: begin
            color_in = elem_q;
            state_in = S_HIST;
         end
         S_HIST: begin
            if (op_add_ff) begin
               hist_we = 1'b1;
               pair_in = pair_ff + 32'(hist_q);
            end else if (hist_q != '0) begin
               hist_we    = 1'b1;
               hist_wdata = hist_q - wepc_pkg::CNT_W'(1);
               pair_in    = pair_ff - 32'(hist_q - wepc_pkg::CNT_W'(1));
            end
            if (ld_ff) begin
               if (!op_add_ff) begin
                  op_add_in = 1'b1;
                  color_in  = col_ff;
                  state_in  = S_LNEW;
               end else begin
                  elem_we  = 1'b1;
                  ld_in    = 1'b0;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_PICK;
            end
         end
         S_LNEW: begin
            state_in = S_HIST;
         end
         S_HAND: begin
            if (red_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         left_ff   <= PW'(1);
         right_ff  <= '0;
         pair_ff   <= '0;
         ld_ff     <= 1'b0;
         err_ff    <= 1'b0;
         op_add_ff <= 1'b0;
         ql_ff     <= PW'(1);
         qr_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         pair_ff   <= pair_in;
         ld_ff     <= ld_in;
         err_ff    <= err_in;
         op_add_ff <= op_add_in;
         ql_ff     <= ql_in;
         qr_ff     <= qr_in;
      end
      idx_ff   <= idx_in;
      col_ff   <= col_in;
      color_ff <= color_in;
      width_ff <= width_in;
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= elem_wdata;
      end
      elem_q <= elem_mem[elem_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_q <= hist_mem[hist_raddr];
   end

   assign ready         = (state_ff == S_IDLE);
   assign red_valid     = (state_ff == S_HAND);
   assign red_req.err   = err_ff;
   assign red_req.pairs = pair_ff;
   assign red_req.width = width_ff;
endmodule

@@ design/wepc_reduce.sv @@
// Fraction reduction: window pair count w*(w-1)/2, binary gcd, restoring division.
// Depends on wepc_pkg.
module wepc_reduce (
   input  logic                  clock,
   input  logic                  reset,
   input  wepc_pkg::red_req_type req,
   input  logic                  req_valid,
   output logic                  req_ready,
   output wepc_pkg::red_rsp_type rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready
);
   typedef enum logic [2:0] {
      R_IDLE, R_MUL, R_DEN, R_CHK, R_GCD, R_DIVN, R_DIVD, R_DONE
   } state_type;

   state_type state_ff, state_in;
   logic err_ff, err_in;
   logic [31:0] num_ff, num_in, den_ff, den_in, a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [31:0] dvd_ff, dvd_in, rem_ff, rem_in;
   logic [16:0] w_ff, w_in;
   logic [33:0] prod_ff, prod_in;
   logic [4:0] k_ff, k_in, cnt_ff, cnt_in;
   wepc_pkg::red_rsp_type res_ff, res_in;
   logic [31:0] rem_sh;
   logic rem_ge;

   always_comb begin
      rem_sh = {rem_ff[30:0], dvd_ff[31]};
      rem_ge = rem_sh >= g_ff;
      state_in = state_ff;
      err_in = err_ff;
      num_in = num_ff;
      den_in = den_ff;
      a_in = a_ff;
      b_in = b_ff;
      g_in = g_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      w_in = w_ff;
      prod_in = prod_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      case (state_ff)
         R_IDLE: begin
            if (req_valid) begin
               err_in = req.err;
               num_in = req.pairs;
               w_in = req.width;
               state_in = R_MUL;
            end
         end
         R_MUL: begin
            prod_in = 34'(w_ff) * 34'(w_ff - 17'd1);
            state_in = R_DEN;
         end
         R_DEN: begin
            den_in = prod_ff[32:1];
            state_in = R_CHK;
         end
         R_CHK: begin
            if (err_ff || num_ff == '0 || den_ff == '0) begin
               res_in.numerator = '0;
               res_in.denominator = 31'd1;
               res_in.status = err_ff ? wepc_pkg::STATUS_ORDER : wepc_pkg::STATUS_OK;
               state_in = R_DONE;
            end else begin
               a_in = num_ff;
               b_in = den_ff;
               k_in = '0;
               state_in = R_GCD;
            end
         end
         R_GCD: begin
            if (a_ff == '0 || b_ff == '0) begin
               g_in = (a_ff | b_ff) << k_ff;
               dvd_in = num_ff;
               rem_in = '0;
               cnt_in = '0;
               state_in = R_DIVN;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 5'd1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end
         R_DIVN, R_DIVD: begin
            rem_in = rem_ge ? (rem_sh - g_ff) : rem_sh;
            dvd_in = {dvd_ff[30:0], rem_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               rem_in = '0;
               cnt_in = '0;
               if (state_ff == R_DIVN) begin
                  res_in.numerator = dvd_in[30:0];
                  dvd_in = den_ff;
                  state_in = R_DIVD;
               end else begin
                  res_in.denominator = dvd_in[30:0];
                  res_in.status = wepc_pkg::STATUS_OK;
                  state_in = R_DONE;
               end
            end
         end
         R_DONE: begin
            if (rsp_ready) begin
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
      err_ff  <= err_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      g_ff    <= g_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign req_ready = (state_ff == R_IDLE);
   assign rsp_valid = (state_ff == R_DONE);
   assign rsp = res_ff;
endmodule
